// File: src/tbw_pkg.sv
package tbw_pkg;

    localparam int COORD_WIDTH_DEF      = 16;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;

    // Result format: signed Q8.16, 24 bits
    localparam int WEIGHT_WIDTH = 24;

    // Quotient bits kept by the divider chain; the top bit marks overflow
    localparam int Q_WIDTH = 27;

    localparam logic [WEIGHT_WIDTH-1:0] W_MAX = 24'h7F_FFFF;
    localparam logic [WEIGHT_WIDTH-1:0] W_MIN = 24'h80_0000;
    localparam logic [Q_WIDTH-2:0]      W_NEG_LIMIT = 26'd8388608;
    localparam logic [Q_WIDTH-2:0]      W_POS_LIMIT = 26'd8388607;

    typedef struct packed {
        logic [2:0] neg;
        logic       deg;
    } flags_t;

endpackage

// File: src/tbw_front.sv
module tbw_front
    import tbw_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int F  = WEIGHT_FRAC_BITS_DEF,
    parameter int SW = 4 * CW + 8,
    parameter int RW = SW + 27 + F
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [CW-1:0] a_x,
    input  logic signed [CW-1:0] a_y,
    input  logic signed [CW-1:0] a_z,
    input  logic signed [CW-1:0] b_x,
    input  logic signed [CW-1:0] b_y,
    input  logic signed [CW-1:0] b_z,
    input  logic signed [CW-1:0] c_x,
    input  logic signed [CW-1:0] c_y,
    input  logic signed [CW-1:0] c_z,
    input  logic signed [CW-1:0] p_x,
    input  logic signed [CW-1:0] p_y,
    input  logic signed [CW-1:0] p_z,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [RW-1:0]        rem [3],
    output logic [SW-1:0]        den,
    output flags_t               flags
);

    localparam int DW = CW + 1;
    localparam int XW = 2 * CW + 3;
    localparam int PW = 2 * XW;
    localparam int NS = 5;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] adv;

    logic signed [CW-1:0] av [3];
    logic signed [CW-1:0] bv [3];
    logic signed [CW-1:0] cv [3];
    logic signed [CW-1:0] pv [3];

    // stage 0: edge vectors, index 0 ab, 1 ac, 2 pa, 3 pb, 4 pc
    logic signed [DW-1:0] dif_reg [5][3];
    logic signed [DW-1:0] dif_next [5][3];
    // stage 1: normal and the three sub-triangle cross products
    logic signed [XW-1:0] crs_reg [4][3];
    logic signed [XW-1:0] crs_next [4][3];
    // stage 2: products against the normal
    logic signed [PW-1:0] prd_reg [4][3];
    logic signed [PW-1:0] prd_next [4][3];
    // stage 3: dot products
    logic signed [SW-1:0] dot_reg [4];
    logic signed [SW-1:0] dot_next [4];
    // stage 4: magnitudes for the divider
    logic [RW-1:0] rem_reg [3];
    logic [RW-1:0] rem_next [3];
    logic [SW-1:0] den_reg;
    flags_t        flags_reg;
    flags_t        flags_next;

    assign av = '{a_x, a_y, a_z};
    assign bv = '{b_x, b_y, b_z};
    assign cv = '{c_x, c_y, c_z};
    assign pv = '{p_x, p_y, p_z};

    always_comb
    begin
        adv[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int s = NS - 2; s >= 0; s--)
        begin
            adv[s] = !vld_reg[s] || adv[s+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NS-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dif_next[0][i] = DW'(bv[i]) - DW'(av[i]);
            dif_next[1][i] = DW'(cv[i]) - DW'(av[i]);
            dif_next[2][i] = DW'(av[i]) - DW'(pv[i]);
            dif_next[3][i] = DW'(bv[i]) - DW'(pv[i]);
            dif_next[4][i] = DW'(cv[i]) - DW'(pv[i]);
        end
    end

    // N = ab x ac, Ka = pb x pc, Kb = pc x pa, Kc = pa x pb
    always_comb
    begin
        logic signed [2*DW-1:0] m0;
        logic signed [2*DW-1:0] m1;
        int                     uix [4];
        int                     vix [4];
        int                     j;
        int                     k;
        uix = '{0, 3, 4, 2};
        vix = '{1, 4, 2, 3};
        for (int m = 0; m < 4; m++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                j  = (i + 1) % 3;
                k  = (i + 2) % 3;
                m0 = dif_reg[uix[m]][j] * dif_reg[vix[m]][k];
                m1 = dif_reg[uix[m]][k] * dif_reg[vix[m]][j];
                crs_next[m][i] = XW'(m0) - XW'(m1);
            end
        end
    end

    always_comb
    begin
        for (int m = 0; m < 4; m++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prd_next[m][i] = crs_reg[m][i] * crs_reg[0][i];
            end
        end
    end

    always_comb
    begin
        for (int m = 0; m < 4; m++)
        begin
            dot_next[m] = SW'(prd_reg[m][0]) + SW'(prd_reg[m][1]) + SW'(prd_reg[m][2]);
        end
    end

    always_comb
    begin
        logic [SW-1:0] mag;
        flags_next.deg = (dot_reg[0] == '0);
        for (int l = 0; l < 3; l++)
        begin
            flags_next.neg[l] = dot_reg[l+1][SW-1];
            mag = flags_next.neg[l] ? SW'(-dot_reg[l+1]) : SW'(dot_reg[l+1]);
            rem_next[l] = RW'(mag) << (F + 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int s = 1; s < NS; s++)
            begin
                if (adv[s])
                begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            dif_reg <= dif_next;
        end
        if (adv[1])
        begin
            crs_reg <= crs_next;
        end
        if (adv[2])
        begin
            prd_reg <= prd_next;
        end
        if (adv[3])
        begin
            dot_reg <= dot_next;
        end
        if (adv[4])
        begin
            rem_reg   <= rem_next;
            den_reg   <= dot_reg[0];
            flags_reg <= flags_next;
        end
    end

    assign rem   = rem_reg;
    assign den   = den_reg;
    assign flags = flags_reg;

endmodule

// File: src/tbw_cell.sv
module tbw_cell
    import tbw_pkg::*;
#(
    parameter int RW    = 107,
    parameter int SW    = 72,
    parameter int SHIFT = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [RW-1:0]      rem_in [3],
    input  logic [SW-1:0]      den_in,
    input  logic [Q_WIDTH-1:0] q_in [3],
    input  flags_t             flags_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [RW-1:0]      rem_out [3],
    output logic [SW-1:0]      den_out,
    output logic [Q_WIDTH-1:0] q_out [3]
    ,
    output flags_t             flags_out
);

    logic               vld_reg;
    logic               adv;
    logic [RW-1:0]      dsh;
    logic [RW-1:0]      rem_reg [3];
    logic [RW-1:0]      rem_next [3];
    logic [Q_WIDTH-1:0] q_reg [3];
    logic [Q_WIDTH-1:0] q_next [3];
    logic [SW-1:0]      den_reg;
    flags_t             flags_reg;

    assign adv      = !vld_reg || out_ready;
    assign in_ready = adv;
    assign dsh      = RW'(den_in) << SHIFT;

    // one restoring step per lane: take the shifted divisor out if it fits
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            rem_next[l] = rem_in[l];
            q_next[l]   = q_in[l];
            if (rem_in[l] >= dsh)
            begin
                rem_next[l]      = rem_in[l] - dsh;
                q_next[l][SHIFT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg   <= rem_next;
            q_reg     <= q_next;
            den_reg   <= den_in;
            flags_reg <= flags_in;
        end
    end

    assign out_valid = vld_reg;
    assign rem_out   = rem_reg;
    assign q_out     = q_reg;
    assign den_out   = den_reg;
    assign flags_out = flags_reg;

endmodule

// File: src/triangle_barycentric_weights.sv
// Barycentric weights of a query point P against a 3D triangle A, B, C.
// Input channel: in_valid / in_ready with twelve signed Q8.8 coordinates.
// Output channel: out_valid / out_ready with weight_a, weight_b, weight_c
// (signed Q8.16, rounded to nearest with ties away from zero, saturated)
// and degenerate, which is set with all weights zero when the triangle
// normal is the zero vector.
// Throughput: one item per cycle, every cycle, as long as the receiver
// takes results. The pipeline has 33 register stages: five arithmetic
// stages (edges, cross products, products, dot sums, magnitude), 27
// divider cells that each retire one quotient bit for all three weights,
// and one rounding and saturation register.
// Every stage has its own valid bit and moves when the stage ahead is free,
// so bubbles close up while the receiver stalls and in_ready drops only
// once every stage holds an item.
// Reset clears every valid bit; out_valid is low and in_ready high after it.
module triangle_barycentric_weights
    import tbw_pkg::*;
#(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] a_x,
    input  logic signed [COORD_WIDTH-1:0] a_y,
    input  logic signed [COORD_WIDTH-1:0] a_z,
    input  logic signed [COORD_WIDTH-1:0] b_x,
    input  logic signed [COORD_WIDTH-1:0] b_y,
    input  logic signed [COORD_WIDTH-1:0] b_z,
    input  logic signed [COORD_WIDTH-1:0] c_x,
    input  logic signed [COORD_WIDTH-1:0] c_y,
    input  logic signed [COORD_WIDTH-1:0] c_z,
    input  logic signed [COORD_WIDTH-1:0] p_x,
    input  logic signed [COORD_WIDTH-1:0] p_y,
    input  logic signed [COORD_WIDTH-1:0] p_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [WEIGHT_WIDTH-1:0] weight_a,
    output logic signed [WEIGHT_WIDTH-1:0] weight_b,
    output logic signed [WEIGHT_WIDTH-1:0] weight_c,
    output logic                          degenerate
);

    // dot products need 4*CW+8 bits; the dividend is shifted up by F+1
    localparam int SW = 4 * COORD_WIDTH + 8;
    localparam int RW = SW + 27 + WEIGHT_FRAC_BITS;
    localparam int NC = Q_WIDTH;

    logic               vld_w   [NC+1];
    logic               rdy_w   [NC+1];
    logic [RW-1:0]      rem_w   [NC][3];
    logic [SW-1:0]      den_w   [NC];
    logic [Q_WIDTH-1:0] q_w     [NC+1][3];
    flags_t             flags_w [NC+1];

    logic                    out_vld_reg;
    logic                    out_adv;
    logic [WEIGHT_WIDTH-1:0] w_reg  [3];
    logic [WEIGHT_WIDTH-1:0] w_next [3];
    logic                    deg_reg;

    tbw_front #(
        .CW (COORD_WIDTH),
        .F  (WEIGHT_FRAC_BITS),
        .SW (SW),
        .RW (RW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .c_x       (c_x),
        .c_y       (c_y),
        .c_z       (c_z),
        .p_x       (p_x),
        .p_y       (p_y),
        .p_z       (p_z),
        .out_valid (vld_w[0]),
        .out_ready (rdy_w[0]),
        .rem       (rem_w[0]),
        .den       (den_w[0]),
        .flags     (flags_w[0])
    );

    assign q_w[0] = '{default: '0};

    // Cell c tests the divisor shifted by NC-1-c; the first cell flags overflow.
    for (genvar c = 0; c < NC; c++)
    begin : g_cell
        if (c < NC - 1)
        begin : g_mid
            tbw_cell #(
                .RW    (RW),
                .SW    (SW),
                .SHIFT (NC - 1 - c)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (vld_w[c]),
                .in_ready  (rdy_w[c]),
                .rem_in    (rem_w[c]),
                .den_in    (den_w[c]),
                .q_in      (q_w[c]),
                .flags_in  (flags_w[c]),
                .out_valid (vld_w[c+1]),
                .out_ready (rdy_w[c+1]),
                .rem_out   (rem_w[c+1]),
                .den_out   (den_w[c+1]),
                .q_out     (q_w[c+1]),
                .flags_out (flags_w[c+1])
            );
        end
        else
        begin : g_last
            tbw_cell #(
                .RW    (RW),
                .SW    (SW),
                .SHIFT (NC - 1 - c)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (vld_w[c]),
                .in_ready  (rdy_w[c]),
                .rem_in    (rem_w[c]),
                .den_in    (den_w[c]),
                .q_in      (q_w[c]),
                .flags_in  (flags_w[c]),
                .out_valid (vld_w[c+1]),
                .out_ready (rdy_w[c+1]),
                .rem_out   (),
                .den_out   (),
                .q_out     (q_w[c+1]),
                .flags_out (flags_w[c+1])
            );
        end
    end

    assign out_adv   = !out_vld_reg || out_ready;
    assign rdy_w[NC] = out_adv;

    // Round the doubled quotient, then apply sign and saturation; a degenerate item gives zero.
    always_comb
    begin
        logic [Q_WIDTH-1:0] qs;
        logic [Q_WIDTH-2:0] qr;
        for (int l = 0; l < 3; l++)
        begin
            qs = q_w[NC][l] + Q_WIDTH'(1);
            qr = qs[Q_WIDTH-1:1];
            if (flags_w[NC].deg)
            begin
                w_next[l] = '0;
            end
            else if (q_w[NC][l][Q_WIDTH-1])
            begin
                w_next[l] = flags_w[NC].neg[l] ? W_MIN : W_MAX;
            end
            else if (flags_w[NC].neg[l])
            begin
                w_next[l] = (qr > W_NEG_LIMIT) ? W_MIN
                                               : WEIGHT_WIDTH'((Q_WIDTH-1)'(0) - qr);
            end
            else
            begin
                w_next[l] = (qr > W_POS_LIMIT) ? W_MAX : WEIGHT_WIDTH'(qr);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_vld_reg <= vld_w[NC];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            w_reg   <= w_next;
            deg_reg <= flags_w[NC].deg;
        end
    end

    assign out_valid  = out_vld_reg;
    assign weight_a   = w_reg[0];
    assign weight_b   = w_reg[1];
    assign weight_c   = w_reg[2];
    assign degenerate = deg_reg;

endmodule

// File: src/tbw_checker.sv
module tbw_checker
    import tbw_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [WEIGHT_WIDTH-1:0] weight_a,
    input logic [WEIGHT_WIDTH-1:0] weight_b,
    input logic [WEIGHT_WIDTH-1:0] weight_c,
    input logic                    degenerate
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(weight_a)
            && $stable(weight_b) && $stable(weight_c) && $stable(degenerate))
        else $error("stalled result changed");

    // a degenerate triangle carries zero weights
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> weight_a == '0 && weight_b == '0 && weight_c == '0)
        else $error("degenerate item with nonzero weights");

    // input side only backs up once the output is stalled
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without an output stall");

    // a drained pipeline cannot refuse input
    a_ready_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input refused while output is empty");

endmodule

bind triangle_barycentric_weights tbw_checker u_tbw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .weight_a   (weight_a),
    .weight_b   (weight_b),
    .weight_c   (weight_c),
    .degenerate (degenerate)
);

// File: bench/tbw_weight_checker.sv
module tbw_weight_checker
    import tbw_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic signed [15:0]             a_x,
    input  logic signed [15:0]             a_y,
    input  logic signed [15:0]             a_z,
    input  logic signed [15:0]             b_x,
    input  logic signed [15:0]             b_y,
    input  logic signed [15:0]             b_z,
    input  logic signed [15:0]             c_x,
    input  logic signed [15:0]             c_y,
    input  logic signed [15:0]             c_z,
    input  logic signed [15:0]             p_x,
    input  logic signed [15:0]             p_y,
    input  logic signed [15:0]             p_z,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic signed [WEIGHT_WIDTH-1:0] weight_a,
    input  logic signed [WEIGHT_WIDTH-1:0] weight_b,
    input  logic signed [WEIGHT_WIDTH-1:0] weight_c,
    input  logic                           degenerate,
    output int                             fail_count,
    output int                             pending
);

    typedef struct {
        logic signed [WEIGHT_WIDTH-1:0] wa;
        logic signed [WEIGHT_WIDTH-1:0] wb;
        logic signed [WEIGHT_WIDTH-1:0] wc;
        logic                           deg;
    } weights_t;

    weights_t weight_q[$];

    // round(num * 2^F / den), ties away from zero, saturated to 24 bits
    function automatic logic signed [WEIGHT_WIDTH-1:0] scaled_ratio(
        input logic signed [127:0] num,
        input logic signed [127:0] den
    );
        logic        neg;
        logic [127:0] mag;
        logic [127:0] q2;
        logic [127:0] q;
        neg = num < 0;
        mag = neg ? -num : num;
        q2  = (mag << (WEIGHT_FRAC_BITS_DEF + 1)) / $unsigned(den);
        if (q2 >= (128'd1 << 26))
            return neg ? W_MIN : W_MAX;
        q = (q2 + 1) >> 1;
        if (neg)
            return (q > 128'd8388608) ? W_MIN : -q[WEIGHT_WIDTH-1:0];
        return (q > 128'd8388607) ? W_MAX : q[WEIGHT_WIDTH-1:0];
    endfunction

    function automatic logic signed [127:0] dot_n(
        input longint u0, input longint u1, input longint u2,
        input longint v0, input longint v1, input longint v2
    );
        logic signed [127:0] s;
        s = 128'(u0) * 128'(v0) + 128'(u1) * 128'(v1) + 128'(u2) * 128'(v2);
        return s;
    endfunction

    function automatic weights_t predict_weights(input longint co[12]);
        weights_t   r;
        longint     ab[3], ac[3], pa[3], pb[3], pc[3], n[3], k[3];
        logic signed [127:0] den;
        for (int i = 0; i < 3; i++)
        begin
            ab[i] = co[3+i] - co[i];
            ac[i] = co[6+i] - co[i];
            pa[i] = co[i]   - co[9+i];
            pb[i] = co[3+i] - co[9+i];
            pc[i] = co[6+i] - co[9+i];
        end
        n[0] = ab[1]*ac[2] - ab[2]*ac[1];
        n[1] = ab[2]*ac[0] - ab[0]*ac[2];
        n[2] = ab[0]*ac[1] - ab[1]*ac[0];
        den  = dot_n(n[0], n[1], n[2], n[0], n[1], n[2]);
        r = '{wa: '0, wb: '0, wc: '0, deg: 1'b1};
        if (den == 0)
            return r;
        r.deg = 1'b0;
        k[0] = pb[1]*pc[2] - pb[2]*pc[1];
        k[1] = pb[2]*pc[0] - pb[0]*pc[2];
        k[2] = pb[0]*pc[1] - pb[1]*pc[0];
        r.wa = scaled_ratio(dot_n(k[0], k[1], k[2], n[0], n[1], n[2]), den);
        k[0] = pc[1]*pa[2] - pc[2]*pa[1];
        k[1] = pc[2]*pa[0] - pc[0]*pa[2];
        k[2] = pc[0]*pa[1] - pc[1]*pa[0];
        r.wb = scaled_ratio(dot_n(k[0], k[1], k[2], n[0], n[1], n[2]), den);
        k[0] = pa[1]*pb[2] - pa[2]*pb[1];
        k[1] = pa[2]*pb[0] - pa[0]*pb[2];
        k[2] = pa[0]*pb[1] - pa[1]*pb[0];
        r.wc = scaled_ratio(dot_n(k[0], k[1], k[2], n[0], n[1], n[2]), den);
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        weights_t w;
        longint   co[12];
        if (!rst_n)
        begin
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (weight_q.size() == 0)
                begin
                    $error("result with no item pending");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    w = weight_q.pop_front();
                    if (weight_a !== w.wa || weight_b !== w.wb ||
                        weight_c !== w.wc || degenerate !== w.deg)
                        fail_count <= fail_count + 1;
                    if (weight_a !== w.wa)
                        $error("weight_a: expected %0d, got %0d", w.wa, weight_a);
                    if (weight_b !== w.wb)
                        $error("weight_b: expected %0d, got %0d", w.wb, weight_b);
                    if (weight_c !== w.wc)
                        $error("weight_c: expected %0d, got %0d", w.wc, weight_c);
                    if (degenerate !== w.deg)
                        $error("degenerate: expected %0d, got %0d", w.deg, degenerate);
                end
            end
            if (in_valid && in_ready)
            begin
                co = '{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, p_x, p_y, p_z};
                weight_q.push_back(predict_weights(co));
            end
            pending <= weight_q.size();
        end
    end

endmodule

// File: bench/triangle_barycentric_weights_tb.sv
module triangle_barycentric_weights_tb;
    import tbw_pkg::*;

    localparam int N_RANDOM   = 900;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_AT    = 300;  // item count that triggers the long receiver stall
    localparam int DRAIN_AT   = 600;  // item count after which the sender drains the pipe

    typedef int coords_t[12];

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] a_x = '0, a_y = '0, a_z = '0;
    logic signed [15:0] b_x = '0, b_y = '0, b_z = '0;
    logic signed [15:0] c_x = '0, c_y = '0, c_z = '0;
    logic signed [15:0] p_x = '0, p_y = '0, p_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [WEIGHT_WIDTH-1:0] weight_a, weight_b, weight_c;
    logic degenerate;

    int fail_count;
    int pending;
    int items_sent = 0;
    logic stim_done = 1'b0;
    int idle_cycles = 0;

    always #2 clk = ~clk;

    triangle_barycentric_weights i_dut (.*);

    tbw_weight_checker i_checker (.*);

    // Present one item and hold it until the handshake completes. Ready is
    // looked at on the falling edge so the decision never races the DUT flops.
    task automatic send_item(input coords_t v);
        in_valid <= 1'b1;
        a_x <= 16'(v[0]); a_y <= 16'(v[1]); a_z <= 16'(v[2]);
        b_x <= 16'(v[3]); b_y <= 16'(v[4]); b_z <= 16'(v[5]);
        c_x <= 16'(v[6]); c_y <= 16'(v[7]); c_z <= 16'(v[8]);
        p_x <= 16'(v[9]); p_y <= 16'(v[10]); p_z <= 16'(v[11]);
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
    endtask

    function automatic int rand_coord();
        return int'($signed(16'($urandom)));
    endfunction

    function automatic int rand_small(input int span);
        return $urandom_range(0, 2*span) - span;
    endfunction

    function automatic int clip(input int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    // Build one random item; the mix leans on shapes that reach the
    // interesting corners: saturation, collinear corners, points inside.
    function automatic coords_t random_item();
        coords_t v;
        int      pick;
        int      sel;
        int      t;
        pick = $urandom_range(0, 9);
        for (int i = 0; i < 12; i++)
            v[i] = rand_coord();
        case (pick)
            4, 5:
            begin
                for (int i = 0; i < 12; i++)
                    v[i] = rand_small(1024);
            end
            6:
            begin
                // tiny triangle, far point: drive the weights into saturation
                for (int i = 0; i < 3; i++)
                begin
                    v[3+i] = clip(v[i] + rand_small(3));
                    v[6+i] = clip(v[i] + rand_small(3));
                end
            end
            7:
            begin
                // collinear corners: C on the line through A and B
                t = rand_small(3);
                for (int i = 0; i < 3; i++)
                begin
                    v[i]   = rand_small(4000);
                    v[3+i] = v[i] + rand_small(2000);
                    v[6+i] = v[i] + t * (v[3+i] - v[i]);
                end
            end
            8:
            begin
                // point inside or near the triangle
                for (int i = 0; i < 3; i++)
                begin
                    v[i]   = rand_small(8000);
                    v[3+i] = rand_small(8000);
                    v[6+i] = rand_small(8000);
                    v[9+i] = clip(v[i] + ((v[3+i] - v[i]) * rand_small(4)) / 4
                                  + ((v[6+i] - v[i]) * rand_small(4)) / 4
                                  + rand_small(16));
                end
            end
            9:
            begin
                for (int i = 0; i < 12; i++)
                begin
                    sel = $urandom_range(0, 3);
                    v[i] = (sel == 0) ? 32767 : (sel == 1) ? -32768 :
                           (sel == 2) ? 0 : v[i];
                end
            end
            default: ;
        endcase
        return v;
    endfunction

    // Sender: directed items, then random bursts with random gaps and one full drain.
    initial
    begin
        coords_t directed[$];
        int      burst_left;
        int      gap;
        directed = '{
            '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 0},
            '{0, 0, 0, 256, 0, 0, 0, 256, 0, 256, 0, 0},
            '{0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 256, 0},
            '{0, 0, 0, 256, 0, 0, 0, 256, 0, 85, 85, 0},
            '{0, 0, 0, 256, 0, 0, 0, 256, 0, 512, 512, 0},
            '{0, 0, 0, 256, 0, 0, 0, 256, 0, 64, 64, 256},
            '{0, 0, 0, 256, 0, 0, 0, 256, 0, -128, 64, -300},
            '{32767, 32767, 32767, 32767, 32767, 32767,
              32767, 32767, 32767, 32767, 32767, 32767},
            '{-32768, -32768, -32768, -32768, -32768, -32768,
              -32768, -32768, -32768, -32768, -32768, -32768},
            '{-32768, -32768, -32768, 32767, -32768, -32768,
              -32768, 32767, 32767, 32767, 32767, 32767},
            '{32767, 32767, 32767, -32768, 32767, 32767,
              32767, -32768, -32768, -32768, -32768, -32768},
            '{0, 0, 0, 1, 0, 0, 0, 1, 0, 32767, 32767, 0},
            '{0, 0, 0, 1, 0, 0, 0, 1, 0, -32768, -32768, 0},
            '{0, 0, 0, 1, 0, 0, 0, 1, 0, 32767, -32768, 32767},
            '{0, 0, 0, 100, 100, 100, 200, 200, 200, 5, -7, 9},
            '{-300, 50, 20, 300, -50, 20, -300, 50, 20, 0, 0, 0},
            '{100, 200, -300, -400, 500, 600, 700, -800, 900, 10, 20, 30},
            '{256, 256, 256, -256, 256, 0, 0, -256, 512, 0, 0, 0},
            '{0, 0, 0, 3, 0, 0, 0, 2, 0, 1, 1, 0},
            '{1, 1, 1, 1, 1, 2, 1, 2, 1, 1, 1, 1}
        };
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_item(directed[i]);
        burst_left = $urandom_range(1, 40);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (items_sent == DRAIN_AT)
            begin
                // stop offering until the pipe has emptied completely
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            else if (burst_left == 0)
            begin
                gap = $urandom_range(0, 8);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 40);
            end
            send_item(random_item());
            burst_left--;
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        stim_done <= 1'b1;
    end

    // Receiver: switch between random stall patterns; once, hold off long
    // enough that every stage fills and in_ready drops.
    initial
    begin
        int  mode;
        bit  held;
        held = 1'b0;
        mode = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            for (int i = 0; i < 64; i++)
            begin
                @(posedge clk);
                if (!held && items_sent >= HOLD_AT)
                begin
                    held = 1'b1;
                    out_ready <= 1'b0;
                    repeat (200) @(posedge clk);
                end
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 1) == 1);
                    2:       out_ready <= ($urandom_range(0, 9) != 0);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("triangle_barycentric_weights test failed");
                $finish;
            end
        end
    end

    initial
    begin
        wait (stim_done);
        if (fail_count == 0)
            $display("triangle_barycentric_weights test passed");
        else
            $display("triangle_barycentric_weights test failed");
        $finish;
    end

endmodule
